// ----- rtl/core/ilu_pkg.sv -----
// ilu_pkg: shared types and constants for the interval list update core.
// No dependencies.
`default_nettype none
package ilu_pkg;

  localparam int NUM_ROWS_DEF   = 64;
  localparam int MAX_SPANS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_CHANGED = 2'd0;
  localparam logic [1:0] STATUS_NOCHG   = 2'd1;
  localparam logic [1:0] STATUS_OVERLAP = 2'd2;
  localparam logic [1:0] STATUS_FULL    = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT,
    ST_SCAN,
    ST_DECIDE,
    ST_POST,
    ST_UP_RD,
    ST_UP_WR,
    ST_UP_FIN,
    ST_DN_RD,
    ST_DN_WR,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/interval_list_update_core.sv -----
// interval_list_update_core: per-row sorted span lists held in a span RAM and a count RAM.
// Depends on ilu_pkg.
// An insert scans the row's spans twice, then shifts the spans from the slot up by one place
// (or down, when a join takes a span out); a remove scans once, then shifts up or down.
// One word in flight; set by the span RAM's single read and write port. Reset: a clearing
// pass over the NUM_ROWS rows zeroes the count RAM.
`default_nettype none
module interval_list_update_core #(
  parameter int NUM_ROWS   = ilu_pkg::NUM_ROWS_DEF,
  parameter int MAX_SPANS  = ilu_pkg::MAX_SPANS_DEF,
  parameter int COORD_BITS = ilu_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire logic                  cmd,
  input  wire logic [5:0]            row,
  input  wire logic [COORD_BITS-1:0] span_low_x,
  input  wire logic [COORD_BITS-1:0] span_high_x,
  input  wire logic [COORD_BITS-1:0] span_low_y,
  input  wire logic [COORD_BITS-1:0] span_high_y,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output logic [1:0]                 status,
  output logic [4:0]                 row_count
);

  localparam int CW    = COORD_BITS;
  localparam int EW    = 4 * CW;
  localparam int NW    = $clog2(MAX_SPANS + 1);
  localparam int DEPTH = NUM_ROWS * MAX_SPANS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  ilu_pkg::state_t state, state_next;

  logic [EW-1:0] span_mem [DEPTH];
  logic [NW-1:0] cnt_mem [NUM_ROWS];
  logic [AW-1:0] sr_addr, sw_addr;
  logic [EW-1:0] sr_data, sw_data;
  logic          sw_en;
  logic [RW-1:0] cr_addr, cw_addr;
  logic [NW-1:0] cr_data, cw_data;
  logic          cw_en;

  logic          cmd_r;
  logic [RW-1:0] row_r, clr_idx;
  logic [AW-1:0] base;
  logic [CW-1:0] s_lx, s_hx, s_ly, s_hy;
  logic [NW-1:0] n0, n_new, idx, j, pos, pre_idx, rem_idx, loc_idx;
  logic          pre_v, rem_v, loc_v, commit, changed;
  logic [EW-1:0] pre_ent, ins_ent;
  logic [1:0]    res_status;
  logic [NW-1:0] res_count;

  logic          accept, row_oor;
  logic [RW-1:0] row_in;
  logic [NW-1:0] n0c;
  logic [CW-1:0] b_lx, b_hx, b_ly, b_hy;
  logic          last, full;
  logic          i_cov, i_tl, i_tr, i_lt, i_gt, i_ovl, i_end;
  logic          r_split, r_exact, r_lo, r_hi, r_end;

  function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] b, input logic [NW-1:0] k);
    return b + AW'(k);
  endfunction

  always_ff @(posedge clk) begin
    if (sw_en) span_mem[sw_addr] <= sw_data;
    sr_data <= span_mem[sr_addr];
  end

  always_ff @(posedge clk) begin
    if (cw_en) cnt_mem[cw_addr] <= cw_data;
    cr_data <= cnt_mem[cr_addr];
  end

  assign req_ready = (state == ilu_pkg::ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign row_oor   = (32'(row) >= NUM_ROWS);
  assign row_in    = RW'(row);
  assign n0c       = (32'(cr_data) > MAX_SPANS) ? NW'(MAX_SPANS) : cr_data;

  assign b_lx = sr_data[CW-1:0];
  assign b_hx = sr_data[2*CW-1:CW];
  assign b_ly = sr_data[3*CW-1:2*CW];
  assign b_hy = sr_data[4*CW-1:3*CW];

  assign last = (idx == n0 - NW'(1));
  assign full = (n0 >= NW'(MAX_SPANS));

  // insert decision, first match wins
  assign i_cov = (b_lx <= s_lx) && (s_hx <= b_hx);
  assign i_tl  = !i_cov && (s_lx == b_hx);
  assign i_tr  = !i_cov && !i_tl && (s_hx == b_lx);
  assign i_lt  = !i_cov && !i_tl && !i_tr && (s_hx < b_lx);
  assign i_gt  = !i_cov && !i_tl && !i_tr && !i_lt && (s_lx > b_hx);
  assign i_ovl = !i_cov && !i_tl && !i_tr && !i_lt && !i_gt;
  assign i_end = i_cov || i_tr || (i_lt && (pre_v || loc_v)) || i_ovl || last;

  assign r_split = (b_lx < s_lx) && (s_hx < b_hx);
  assign r_exact = !r_split && (b_lx == s_lx) && (s_hx == b_hx);
  assign r_lo    = !r_split && !r_exact && (s_lx == b_lx);
  assign r_hi    = !r_split && !r_exact && !r_lo && (s_hx == b_hx);
  assign r_end   = r_split || r_exact || r_lo || r_hi || last;

  always_comb begin
    state_next = state;
    unique case (state)
      ilu_pkg::ST_CLEAR:
        if (clr_idx == RW'(NUM_ROWS - 1)) state_next = ilu_pkg::ST_IDLE;
      ilu_pkg::ST_IDLE:
        if (accept) state_next = row_oor ? ilu_pkg::ST_DONE : ilu_pkg::ST_CNT;
      ilu_pkg::ST_CNT: begin
        if (n0c != '0) state_next = ilu_pkg::ST_SCAN;
        else if (cmd_r == ilu_pkg::CMD_INSERT) state_next = ilu_pkg::ST_FIN;
        else state_next = ilu_pkg::ST_DONE;
      end
      ilu_pkg::ST_SCAN: begin
        if (cmd_r == ilu_pkg::CMD_INSERT) begin
          if (i_end) begin
            if (i_ovl) state_next = ilu_pkg::ST_DONE;
            else state_next = commit ? ilu_pkg::ST_POST : ilu_pkg::ST_DECIDE;
          end
        end else if (r_end) begin
          priority if (r_split) begin
            if (full) state_next = ilu_pkg::ST_DONE;
            else if (idx + NW'(1) == n0) state_next = ilu_pkg::ST_UP_FIN;
            else state_next = ilu_pkg::ST_UP_RD;
          end else if (r_exact) begin
            state_next = last ? ilu_pkg::ST_FIN : ilu_pkg::ST_DN_RD;
          end else begin
            state_next = ilu_pkg::ST_FIN;
          end
        end
      end
      ilu_pkg::ST_DECIDE:
        state_next = (loc_v && full) ? ilu_pkg::ST_DONE : ilu_pkg::ST_SCAN;
      ilu_pkg::ST_POST: begin
        priority if (rem_v)
          state_next = (rem_idx == n0 - NW'(1)) ? ilu_pkg::ST_FIN : ilu_pkg::ST_DN_RD;
        else if (loc_v)
          state_next = (loc_idx == n0) ? ilu_pkg::ST_UP_FIN : ilu_pkg::ST_UP_RD;
        else
          state_next = ilu_pkg::ST_FIN;
      end
      ilu_pkg::ST_UP_RD:  state_next = ilu_pkg::ST_UP_WR;
      ilu_pkg::ST_UP_WR:  state_next = (j == pos) ? ilu_pkg::ST_UP_FIN : ilu_pkg::ST_UP_RD;
      ilu_pkg::ST_UP_FIN: state_next = ilu_pkg::ST_FIN;
      ilu_pkg::ST_DN_RD:  state_next = ilu_pkg::ST_DN_WR;
      ilu_pkg::ST_DN_WR:
        state_next = (j == n0 - NW'(1)) ? ilu_pkg::ST_FIN : ilu_pkg::ST_DN_RD;
      ilu_pkg::ST_FIN:    state_next = ilu_pkg::ST_DONE;
      ilu_pkg::ST_DONE:
        if (!rsp_valid || rsp_ready) state_next = ilu_pkg::ST_IDLE;
      default: state_next = ilu_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    sr_addr = addr_of(base, '0);
    sw_en   = 1'b0;
    sw_addr = addr_of(base, idx);
    sw_data = {b_hy, b_ly, b_hx, b_lx};
    cr_addr = row_in;
    cw_en   = 1'b0;
    cw_addr = row_r;
    cw_data = n_new;
    unique case (state)
      ilu_pkg::ST_CLEAR: begin
        cw_en   = 1'b1;
        cw_addr = clr_idx;
        cw_data = '0;
      end
      ilu_pkg::ST_CNT: begin
        sw_en   = (n0c == '0) && (cmd_r == ilu_pkg::CMD_INSERT);
        sw_addr = addr_of(base, '0);
        sw_data = {s_hy, s_ly, s_hx, s_lx};
      end
      ilu_pkg::ST_SCAN: begin
        sr_addr = addr_of(base, idx + NW'(1));
        if (cmd_r == ilu_pkg::CMD_INSERT) begin
          if (commit && i_tl) begin
            sw_en   = 1'b1;
            sw_data = {b_hy, b_ly, s_hx, b_lx};
          end else if (commit && i_tr) begin
            sw_en = 1'b1;
            if (pre_v) begin
              sw_addr = addr_of(base, pre_idx);
              sw_data = {pre_ent[EW-1:2*CW], b_hx, pre_ent[CW-1:0]};
            end else begin
              sw_data = {b_hy, b_ly, b_hx, s_lx};
            end
          end
        end else begin
          priority if (r_split) begin
            sw_en   = !full;
            sw_data = {b_hy, b_ly, s_lx, b_lx};
          end else if (r_exact) begin
            sw_en = 1'b0;
          end else if (r_lo) begin
            sw_en   = 1'b1;
            sw_data = {b_hy, b_ly, b_hx, s_hx};
          end else if (r_hi) begin
            sw_en   = 1'b1;
            sw_data = {b_hy, b_ly, s_lx, b_lx};
          end else begin
            sw_en = 1'b0;
          end
        end
      end
      ilu_pkg::ST_UP_RD, ilu_pkg::ST_DN_RD: sr_addr = addr_of(base, j);
      ilu_pkg::ST_UP_WR: begin
        sw_en   = 1'b1;
        sw_addr = addr_of(base, j + NW'(1));
        sw_data = sr_data;
      end
      ilu_pkg::ST_DN_WR: begin
        sw_en   = 1'b1;
        sw_addr = addr_of(base, j - NW'(1));
        sw_data = sr_data;
      end
      ilu_pkg::ST_UP_FIN: begin
        sw_en   = 1'b1;
        sw_addr = addr_of(base, pos);
        sw_data = ins_ent;
      end
      ilu_pkg::ST_FIN: cw_en = changed;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ilu_pkg::ST_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ilu_pkg::ST_CLEAR) clr_idx <= clr_idx + RW'(1);
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      if (state == ilu_pkg::ST_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
        status    <= res_status;
        row_count <= 5'(res_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ilu_pkg::ST_IDLE:
        if (accept) begin
          cmd_r      <= cmd;
          row_r      <= row_in;
          base       <= AW'(32'(row_in) * MAX_SPANS);
          s_lx       <= CW'(span_low_x);
          s_hx       <= CW'(span_high_x);
          s_ly       <= CW'(span_low_y);
          s_hy       <= CW'(span_high_y);
          res_status <= ilu_pkg::STATUS_NOCHG;
          res_count  <= '0;
        end
      ilu_pkg::ST_CNT: begin
        n0      <= n0c;
        n_new   <= (n0c == '0) ? NW'(1) : n0c;
        changed <= (n0c == '0) && (cmd_r == ilu_pkg::CMD_INSERT);
        idx     <= '0;
        commit  <= 1'b0;
        pre_v   <= 1'b0;
        rem_v   <= 1'b0;
        loc_v   <= 1'b0;
        res_status <= ilu_pkg::STATUS_NOCHG;
        res_count  <= '0;
      end
      ilu_pkg::ST_SCAN: begin
        if (cmd_r == ilu_pkg::CMD_INSERT) begin
          priority if (i_cov) begin
            loc_v <= 1'b0;
            rem_v <= 1'b0;
          end else if (i_tl) begin
            pre_v   <= 1'b1;
            pre_idx <= idx;
            loc_v   <= 1'b0;
            if (commit) begin
              pre_ent <= {b_hy, b_ly, s_hx, b_lx};
              changed <= changed || (b_hx != s_hx);
            end
          end else if (i_tr) begin
            loc_v <= 1'b0;
            if (pre_v) begin
              rem_v   <= 1'b1;
              rem_idx <= idx;
            end else if (commit) begin
              changed <= changed || (b_lx != s_lx);
            end
          end else if (i_lt) begin
            if (!pre_v && !loc_v) begin
              loc_v   <= 1'b1;
              loc_idx <= idx;
            end
          end else if (i_gt) begin
            loc_v   <= 1'b1;
            loc_idx <= idx + NW'(1);
          end else begin
            res_status <= ilu_pkg::STATUS_OVERLAP;
            res_count  <= n0;
          end
          if (!i_end) idx <= idx + NW'(1);
        end else begin
          priority if (r_split) begin
            if (full) begin
              res_status <= ilu_pkg::STATUS_FULL;
              res_count  <= n0;
            end
            ins_ent <= {s_hy, s_ly, b_hx, s_hx};
            pos     <= idx + NW'(1);
            j       <= n0 - NW'(1);
            changed <= 1'b1;
            n_new   <= n0 + NW'(1);
          end else if (r_exact) begin
            j       <= idx + NW'(1);
            changed <= 1'b1;
            n_new   <= n0 - NW'(1);
          end else if (r_lo) begin
            changed <= (b_lx != s_hx);
          end else if (r_hi) begin
            changed <= (b_hx != s_lx);
          end else begin
            idx <= idx + NW'(1);
          end
        end
      end
      ilu_pkg::ST_DECIDE: begin
        if (loc_v && full) begin
          res_status <= ilu_pkg::STATUS_FULL;
          res_count  <= n0;
        end
        commit <= 1'b1;
        idx    <= '0;
        pre_v  <= 1'b0;
        rem_v  <= 1'b0;
        loc_v  <= 1'b0;
      end
      ilu_pkg::ST_POST: begin
        ins_ent <= {s_hy, s_ly, s_hx, s_lx};
        priority if (rem_v) begin
          changed <= 1'b1;
          n_new   <= n0 - NW'(1);
          j       <= rem_idx + NW'(1);
        end else if (loc_v) begin
          changed <= 1'b1;
          n_new   <= n0 + NW'(1);
          pos     <= loc_idx;
          j       <= n0 - NW'(1);
        end else begin
          n_new <= n0;
        end
      end
      ilu_pkg::ST_UP_WR: j <= j - NW'(1);
      ilu_pkg::ST_DN_WR: j <= j + NW'(1);
      ilu_pkg::ST_FIN: begin
        res_status <= changed ? ilu_pkg::STATUS_CHANGED : ilu_pkg::STATUS_NOCHG;
        res_count  <= changed ? n_new : n0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/ilu_checker.sv -----
// ilu_checker: port-level assertions for interval_list_update_core, bound to the top level.
// Depends on ilu_pkg and interval_list_update_core.
`default_nettype none
module ilu_checker #(
  parameter int MAX_SPANS = ilu_pkg::MAX_SPANS_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [1:0] status,
  input wire logic [4:0] row_count
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(row_count))
    else $error("response word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a word is in progress");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(row_count) <= MAX_SPANS)
    else $error("row count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ilu_pkg::STATUS_FULL |-> 32'(row_count) == MAX_SPANS)
    else $error("row full reported on a row that is not full");

endmodule

bind interval_list_update_core ilu_checker #(.MAX_SPANS(MAX_SPANS)) u_ilu_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .status(status),
  .row_count(row_count)
);
`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for interval_list_update_core, directed then random span
// requests; a behavioural model of the per-row span lists predicts each response word.
// Depends on ilu_pkg and interval_list_update_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS  = 64;
  localparam int SPANS = 16;
  localparam int WDOG  = 20000;

  typedef struct packed {
    logic [15:0] lx, hx, ly, hy;
  } span_t;

  typedef struct packed {
    logic [1:0] st;
    logic [4:0] cnt;
  } resp_t;

  logic        clk = 0, rst = 1;
  logic        req_valid = 0, rsp_ready = 0;
  logic        cmd = ilu_pkg::CMD_INSERT;
  logic [5:0]  row = 0;
  logic [15:0] span_low_x = 0, span_high_x = 0, span_low_y = 0, span_high_y = 0;
  logic        req_ready, rsp_valid;
  logic [1:0]  status;
  logic [4:0]  row_count;

  span_t lists [ROWS][SPANS];
  int    counts [ROWS];
  resp_t pending_resp [$];
  int    errors = 0;
  int    idle_cycles = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  interval_list_update_core u_dut (
    .clk, .rst, .req_valid, .req_ready, .cmd, .row, .span_low_x, .span_high_x,
    .span_low_y, .span_high_y, .rsp_valid, .rsp_ready, .status, .row_count
  );

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // model of one row update
  function automatic logic [1:0] apply_insert(ref span_t w[$], input span_t s);
    int pre = -1, rem = -1, loc = -1;
    if (w.size() == 0) begin
      w.insert(w.size(), s);
      return ilu_pkg::STATUS_CHANGED;
    end
    for (int i = 0; i < w.size(); i++) begin
      if (w[i].lx <= s.lx && s.hx <= w[i].hx) begin
        rem = -1; loc = -1;
        break;
      end else if (s.lx == w[i].hx) begin
        w[i].hx = s.hx; pre = i; loc = -1;
      end else if (s.hx == w[i].lx) begin
        if (pre >= 0) begin
          w[pre].hx = w[i].hx; rem = i;
        end else begin
          w[i].lx = s.lx;
        end
        loc = -1;
        break;
      end else if (s.hx < w[i].lx) begin
        if (pre == -1 && loc == -1) loc = i;
        else break;
      end else if (s.lx > w[i].hx) begin
        loc = i + 1;
      end else begin
        return ilu_pkg::STATUS_OVERLAP;
      end
    end
    if (rem >= 0) w.delete(rem);
    if (loc >= 0) begin
      if (w.size() >= SPANS) return ilu_pkg::STATUS_FULL;
      w.insert(loc, s);
    end
    return ilu_pkg::STATUS_CHANGED;
  endfunction

  function automatic logic [1:0] apply_remove(ref span_t w[$], input span_t s);
    span_t r;
    for (int i = 0; i < w.size(); i++) begin
      if (w[i].lx < s.lx && s.hx < w[i].hx) begin
        if (w.size() >= SPANS) return ilu_pkg::STATUS_FULL;
        r = '{lx: s.hx, hx: w[i].hx, ly: s.ly, hy: s.hy};
        w[i].hx = s.lx;
        w.insert(i + 1, r);
        return ilu_pkg::STATUS_CHANGED;
      end else if (w[i].lx == s.lx && s.hx == w[i].hx) begin
        w.delete(i);
        return ilu_pkg::STATUS_CHANGED;
      end else if (s.lx == w[i].lx) begin
        w[i].lx = s.hx;
        return ilu_pkg::STATUS_CHANGED;
      end else if (s.hx == w[i].hx) begin
        w[i].hx = s.lx;
        return ilu_pkg::STATUS_CHANGED;
      end
    end
    return ilu_pkg::STATUS_CHANGED;
  endfunction

  function automatic resp_t predict_update(logic c, int r, span_t s);
    span_t w[$];
    logic [1:0] st;
    bit same;
    for (int i = 0; i < counts[r]; i++) w.insert(w.size(), lists[r][i]);
    st = (c == ilu_pkg::CMD_INSERT) ? apply_insert(w, s) : apply_remove(w, s);
    if (st == ilu_pkg::STATUS_CHANGED) begin
      same = (w.size() == counts[r]);
      for (int i = 0; same && i < counts[r]; i++) if (w[i] != lists[r][i]) same = 0;
      if (same) st = ilu_pkg::STATUS_NOCHG;
      else begin
        for (int i = 0; i < w.size(); i++) lists[r][i] = w[i];
        counts[r] = w.size();
      end
    end
    return '{st: st, cnt: counts[r][4:0]};
  endfunction

  task automatic send_word(logic c, int r, int lx, int hx, int ly, int hy);
    span_t s;
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    s = '{lx: lx[15:0], hx: hx[15:0], ly: ly[15:0], hy: hy[15:0]};
    req_valid <= 1;
    cmd <= c; row <= r[5:0];
    span_low_x <= s.lx; span_high_x <= s.hx; span_low_y <= s.ly; span_high_y <= s.hy;
    do @(posedge clk); while (!req_ready);
    pending_resp.insert(pending_resp.size(), predict_update(c, r, s));
  endtask

  task automatic drain;
    req_valid <= 0;
    while (pending_resp.size() != 0) @(posedge clk);
  endtask

  // receiver and checker
  initial begin
    resp_t want;
    int stall;
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) begin
        if (pending_resp.size() == 0) report("unexpected word", 0, 0);
        else begin
          want = pending_resp.pop_front();
          if (status !== want.st) report("status", status, want.st);
          if (row_count !== want.cnt) report("row_count", row_count, want.cnt);
        end
      end
      if (stall > 0) begin
        stall--;
        rsp_ready <= 0;
      end else if (rsp_valid && rsp_ready) begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        rsp_ready <= (stall == 0);
      end else rsp_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed;
    send_word(ilu_pkg::CMD_REMOVE, 0, 5, 10, 0, 0);            // remove from empty row
    send_word(ilu_pkg::CMD_INSERT, 0, 100, 200, 1, 2);         // empty row
    send_word(ilu_pkg::CMD_INSERT, 0, 120, 150, 3, 4);         // covered
    send_word(ilu_pkg::CMD_INSERT, 0, 150, 250, 3, 4);         // overlap
    send_word(ilu_pkg::CMD_INSERT, 0, 300, 400, 5, 6);         // sorted placement
    send_word(ilu_pkg::CMD_INSERT, 0, 0, 50, 7, 8);
    send_word(ilu_pkg::CMD_INSERT, 0, 200, 300, 9, 9);         // join both
    send_word(ilu_pkg::CMD_INSERT, 0, 400, 450, 9, 9);         // extend left
    send_word(ilu_pkg::CMD_INSERT, 0, 60, 100, 9, 9);          // extend right
    send_word(ilu_pkg::CMD_REMOVE, 0, 200, 210, 11, 12);       // split
    send_word(ilu_pkg::CMD_REMOVE, 0, 0, 50, 0, 0);            // exact erase
    send_word(ilu_pkg::CMD_REMOVE, 0, 60, 70, 0, 0);           // trim low
    send_word(ilu_pkg::CMD_REMOVE, 0, 440, 450, 0, 0);         // trim high
    send_word(ilu_pkg::CMD_INSERT, 1, 500, 400, 0, 0);         // degenerate
    send_word(ilu_pkg::CMD_INSERT, 63, 0, 16'hffff, 16'hffff, 16'hffff);
    send_word(ilu_pkg::CMD_REMOVE, 63, 16'hfff0, 16'hffff, 16'hffff, 0);
    for (int i = 0; i < 17; i++)
      send_word(ilu_pkg::CMD_INSERT, 2, i * 10, i * 10 + 5, i, i);
    drain();
  endtask

  task automatic test_fill_split;
    for (int i = 0; i < 16; i++)
      send_word(ilu_pkg::CMD_INSERT, 3, i * 100, i * 100 + 50, 0, 0);
    send_word(ilu_pkg::CMD_REMOVE, 3, 10, 20, 0, 0);           // split on full row
    drain();                                                    // hold off until all words are back
  endtask

  task automatic test_random(int n);
    int r, lx, w, k;
    for (int i = 0; i < n; i++) begin
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(4, 11);
      k = $urandom_range(0, 9);
      if (k == 0) begin
        send_word(1'($urandom_range(0, 1)), r, $urandom, $urandom, $urandom, $urandom);
      end else begin
        lx = $urandom_range(0, 40) * 8;
        w = $urandom_range(0, 6) * 4;
        if (k <= 5) send_word(ilu_pkg::CMD_INSERT, r, lx, lx + w, $urandom, $urandom);
        else send_word(ilu_pkg::CMD_REMOVE, r, lx, lx + w, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < ROWS; i++) counts[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    test_directed();
    test_fill_split();
    test_random(1700);
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/ilu_pkg.sv
rtl/core/interval_list_update_core.sv
rtl/core/ilu_checker.sv
test/tb_top.sv
